// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants and types of the linear-probe hash table: table geometry,
// request codes, slot kinds and the layout of one slot in the slot RAM.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Table geometry (slot count must be a power of two: home slot = low key bits)
  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int COUNT_BITS  = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  // Request codes
  localparam logic [1:0] REQ_UPSERT = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Slot kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_LIVE  = 2'd1;
  localparam logic [1:0] KIND_TOMB  = 2'd2;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One slot as stored in the slot RAM
  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage : lpht_pkg
`default_nettype wire

// ===== rtl/core/lpht_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_in_if
// Request channel: valid/ready handshake with request type, key and value.
// ----------------------------------------------------------------------------
interface lpht_in_if
  import lpht_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [KEY_BITS-1:0]   key;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface : lpht_in_if
`default_nettype wire

// ===== rtl/core/lpht_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_out_if
// Result channel: valid/ready handshake with found flag, value, status and
// live entry count.
// ----------------------------------------------------------------------------
interface lpht_out_if
  import lpht_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic signed [VALUE_BITS-1:0] value_out;
  logic                         status;
  logic [COUNT_BITS-1:0]        entry_count;

  modport source (output valid, found, value_out, status, entry_count, input ready);
  modport sink   (input valid, found, value_out, status, entry_count, output ready);
endinterface : lpht_out_if
`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// A request is accepted and then probes the table slot by slot: the slot
// RAM is read once per probe, pipelined so a new slot is checked every cycle,
// and the chain ends at the key, at an empty slot, or after all 64 slots.
// One request is in flight at a time; the result sits in an output register,
// so the next request is taken while it waits. Slot kinds reset to empty
// through one valid bit per slot, so reset and clear take effect at once
// with no sweep. Upsert that finds no live key and no free slot returns
// status full.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  // Control state
  logic [1:0]             state_r, state_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [COUNT_BITS-1:0]  live_r, live_nxt;
  logic [SLOT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                   free_vld_r, free_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Request and probe payload
  logic [1:0]                   req_r, req_nxt;
  logic signed [KEY_BITS-1:0]   key_r, key_nxt;
  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SLOT_BITS-1:0]         idx_r, idx_nxt;
  logic [SLOT_BITS-1:0]         free_idx_r, free_idx_nxt;

  // Result register
  logic                         found_r, found_nxt;
  logic signed [VALUE_BITS-1:0] vout_r, vout_nxt;
  logic                         status_r, status_nxt;

  // Slot RAM ports
  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
  slot_t                ram_wdata, ram_rdata;

  lpht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Probe decode of the slot read back this cycle
  logic [1:0] kind_cur;
  logic       key_hit;
  logic       last_probe;
  logic       chain_end;
  logic       out_free;
  logic       free_any;
  logic [SLOT_BITS-1:0] free_sel;

  assign kind_cur   = valid_r[idx_r] ? ram_rdata.kind : KIND_EMPTY;
  assign key_hit    = (kind_cur == KIND_LIVE) && (ram_rdata.key == key_r);
  assign last_probe = (cnt_r == SLOT_BITS'(TABLE_SLOTS - 1));
  assign chain_end  = (kind_cur == KIND_EMPTY) || key_hit || last_probe;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign free_any   = free_vld_r || (kind_cur != KIND_LIVE);
  assign free_sel   = free_vld_r ? free_idx_r : idx_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    live_nxt      = live_r;
    cnt_nxt       = cnt_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    vout_nxt      = vout_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_raddr     = idx_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '{kind: KIND_LIVE, key: key_r, value: val_r};

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = in_ch.key[SLOT_BITS-1:0];
        if (in_ch.valid) begin
          req_nxt      = in_ch.req_type;
          key_nxt      = in_ch.key;
          val_nxt      = in_ch.value;
          idx_nxt      = in_ch.key[SLOT_BITS-1:0];
          cnt_nxt      = '0;
          free_vld_nxt = 1'b0;
          if (in_ch.req_type == REQ_CLEAR) begin
            valid_nxt = '0;
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        if (!chain_end) begin
          // Step to the next slot; read it so its data lands next cycle
          idx_nxt   = idx_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
          if (!free_vld_r && kind_cur == KIND_TOMB) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
        end else if (out_free) begin
          // Chain resolved: write the slot where the request changes it and load the result
          found_nxt     = key_hit;
          vout_nxt      = '0;
          status_nxt    = STATUS_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          case (req_r)
            REQ_UPSERT: begin
              if (key_hit) begin
                ram_we   = 1'b1;
                vout_nxt = val_r;
              end else if (free_any) begin
                ram_we    = 1'b1;
                ram_waddr = free_sel;
                valid_nxt[free_sel] = 1'b1;
                live_nxt  = live_r + 1'b1;
                vout_nxt  = val_r;
              end else begin
                status_nxt = STATUS_FULL;
              end
            end
            REQ_ERASE: begin
              if (key_hit) begin
                ram_we    = 1'b1;
                ram_wdata = '{kind: KIND_TOMB, key: ram_rdata.key, value: ram_rdata.value};
                if (live_r != '0) begin
                  live_nxt = live_r - 1'b1;
                end
              end
            end
            default: begin
              if (key_hit) begin
                vout_nxt = ram_rdata.value;
              end
            end
          endcase
        end
        // otherwise hold: the same slot is read again until the result can go
      end

      ST_CLEAR: begin
        // Live count drives the result port, so it drops only with the result
        if (out_free) begin
          live_nxt      = '0;
          found_nxt     = 1'b0;
          vout_nxt      = '0;
          status_nxt    = STATUS_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      live_r      <= '0;
      cnt_r       <= '0;
      free_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      live_r      <= live_nxt;
      cnt_r       <= cnt_nxt;
      free_vld_r  <= free_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    free_idx_r <= free_idx_nxt;
    found_r    <= found_nxt;
    vout_r     <= vout_nxt;
    status_r   <= status_nxt;
  end

  // Channel outputs
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.value_out   = vout_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = live_r;

endmodule : linear_probe_hash_table
`default_nettype wire

// ===== rtl/core/lpht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Read of an address written in the same cycle returns the old
// contents.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule : lpht_ram
`default_nettype wire
